// ===== rtl/core/ssb_pkg.sv =====
// Shared types for the Shell sort byte unit: item structs and sequencer states.
// No dependencies.
package ssb_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0] sorted_byte;
        logic       end_of_run;
        logic       overflowed;
    } out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_GAP,
        ST_RD_KEY,
        ST_KEY,
        ST_CMP,
        ST_WR_KEY,
        ST_ADV,
        ST_EM_RD,
        ST_EM_WAIT
    } state_t;

endpackage

// ===== rtl/core/ssb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/shell_sort_bytes_unit.sv =====
// Sequence: after the last item, gap setup, then per pass each element from the gap up
// is read as key and shifted down by the gap until placed, then the results are emitted.
// Throughput: one input item per cycle while loading; each result is registered before
// the next is read. Loading resumes once the final result is in the output register.
// Reset: aresetn synchronous active low; clears count, overflow flag, state, out valid.
// Depends on ssb_pkg and ssb_ram.
module shell_sort_bytes_unit
    import ssb_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   gap_reg, gap_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [7:0]      key_reg, key_next;
    out_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic            in_acc;
    logic            smaller;
    logic [AW-1:0]   j_dec;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   k_inc;
    logic [CW-1:0]   half_count;
    logic [AW-1:0]   half_gap;
    logic            out_free;

    ssb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_acc     = s_valid && s_ready;
    assign smaller    = key_reg < ram_rdata;
    assign j_dec      = j_reg - gap_reg;
    assign i_inc      = CW'(i_reg) + CW'(1);
    assign k_inc      = CW'(k_reg) + CW'(1);
    assign half_count = count_reg >> 1;
    assign half_gap   = gap_reg >> 1;
    assign out_free   = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_data.is_last) begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP: begin
                state_next = (half_count == '0) ? ST_EM_RD : ST_RD_KEY;
            end
            ST_RD_KEY: state_next = ST_KEY;
            ST_KEY:    state_next = ST_CMP;
            ST_CMP: begin
                if (!smaller) begin
                    state_next = ST_ADV;
                end else if (j_dec < gap_reg) begin
                    state_next = ST_WR_KEY;
                end
            end
            ST_WR_KEY: state_next = ST_ADV;
            ST_ADV: begin
                if (i_inc < count_reg) begin
                    state_next = ST_RD_KEY;
                end else begin
                    state_next = (half_gap == '0) ? ST_EM_RD : ST_RD_KEY;
                end
            end
            ST_EM_RD: begin
                if (out_free) begin
                    state_next = ST_EM_WAIT;
                end
            end
            ST_EM_WAIT: begin
                state_next = (k_inc == count_reg) ? ST_LOAD : ST_EM_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_LOAD);
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        gap_next       = gap_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ram_we         = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = key_reg;
        ram_re         = 1'b0;
        ram_raddr      = i_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (count_reg < CW'(MAX_LEN)) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = s_data.data_byte;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_GAP: begin
                gap_next = half_count[AW-1:0];
                i_next   = half_count[AW-1:0];
                k_next   = '0;
            end
            ST_RD_KEY: begin
                ram_re    = 1'b1;
                ram_raddr = i_reg;
            end
            ST_KEY: begin
                key_next  = ram_rdata;
                j_next    = i_reg;
                ram_re    = 1'b1;
                ram_raddr = i_reg - gap_reg;
            end
            ST_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                if (smaller) begin
                    ram_wdata = ram_rdata;
                    j_next    = j_dec;
                    ram_re    = 1'b1;
                    ram_raddr = j_dec - gap_reg;
                end else begin
                    ram_wdata = key_reg;
                end
            end
            ST_WR_KEY: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = key_reg;
            end
            ST_ADV: begin
                k_next = '0;
                if (i_inc < count_reg) begin
                    i_next = i_inc[AW-1:0];
                end else begin
                    gap_next = half_gap;
                    i_next   = half_gap;
                end
            end
            ST_EM_RD: begin
                if (out_free) begin
                    ram_re    = 1'b1;
                    ram_raddr = k_reg;
                end
            end
            ST_EM_WAIT: begin
                out_next.sorted_byte = ram_rdata;
                out_next.end_of_run  = (k_inc == count_reg);
                out_next.overflowed  = ovf_reg;
                out_valid_next       = 1'b1;
                if (k_inc == count_reg) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end else begin
                    k_next = k_inc[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg <= gap_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_LEN))
        else $error("stored count above capacity");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EM_WAIT |-> !out_valid_reg)
        else $error("output register overwritten while holding an item");

    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_RD || state_reg == ST_EM_WAIT) |-> !ram_we)
        else $error("store written during emission");

    a_cmp_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> (j_reg >= gap_reg && gap_reg != '0))
        else $error("compare index below gap");

    a_ready_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.is_last) |=> state_reg == ST_GAP)
        else $error("last item did not start the sort");

endmodule
